### rtl/button_press_pattern_classifier_core_defines.svh
// ----------------------------------------------------------------------------
// Button press pattern classifier: assertion macros
// Shared assertion forms for the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_PATTERN_CLASSIFIER_CORE_DEFINES_SVH
`define BUTTON_PRESS_PATTERN_CLASSIFIER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bppc_pkg.sv
// ----------------------------------------------------------------------------
// Button press pattern classifier package
// Widths, reset values, register indexes and pattern codes.
// ----------------------------------------------------------------------------
package bppc_pkg;

  localparam int TIME_BITS_DEFAULT   = 32;
  localparam int SAMPLE_BITS_DEFAULT = 10;

  localparam int THRESH_BITS = 10;
  localparam int LIMIT_BITS  = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int PATTERN_BITS = 3;

  typedef logic [PATTERN_BITS-1:0] pattern_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PRESS_THRESHOLD = 2'd0;
  localparam cfg_idx_t REG_SEPARATION      = 2'd1;
  localparam cfg_idx_t REG_SHORT_LIMIT     = 2'd2;
  localparam cfg_idx_t REG_MEDIUM_LIMIT    = 2'd3;

  localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET  = 10'd1000;
  localparam logic [LIMIT_BITS-1:0]  SEPARATION_RESET = 16'd300;
  localparam logic [LIMIT_BITS-1:0]  SHORT_RESET      = 16'd500;
  localparam logic [LIMIT_BITS-1:0]  MEDIUM_RESET     = 16'd1500;

  localparam pattern_t PAT_SINGLE_SHORT  = 3'd0;
  localparam pattern_t PAT_SINGLE_MEDIUM = 3'd1;
  localparam pattern_t PAT_SINGLE_LONG   = 3'd2;
  localparam pattern_t PAT_DOUBLE_SHORT  = 3'd3;
  localparam pattern_t PAT_DOUBLE_LONG   = 3'd4;

  localparam int STAMP_PRESS1   = 0;
  localparam int STAMP_RELEASE1 = 1;
  localparam int STAMP_PRESS2   = 2;
  localparam int STAMP_RELEASE2 = 3;

endpackage

### rtl/button_press_pattern_classifier_core.sv
// ----------------------------------------------------------------------------
// Button press pattern classifier core
// Stamps press and release edges on a tick count and reports single or
// double press patterns classified by the first hold time.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                           Direction
//   input    in_valid, in_stall, sample        sample in, stall out
//   output   out_valid, out_stall, pattern     pattern out, stall in
//   config   cfg_valid, cfg_ready, cfg_index,  write in, ready out
//            cfg_data
//
// One item is accepted per cycle unless input stalls; a pattern it completes
// is registered and offered on the next cycle if the result queue was empty.
// Two queue entries let input continue; it stalls only when both are occupied.
// Reset is synchronous and clears the registers to their default values,
// the tick count, the edge state and the result queue.
// ----------------------------------------------------------------------------
`include "button_press_pattern_classifier_core_defines.svh"

module button_press_pattern_classifier_core #(
  parameter int TIME_BITS   = bppc_pkg::TIME_BITS_DEFAULT,
  parameter int SAMPLE_BITS = bppc_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [SAMPLE_BITS-1:0]        sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bppc_pkg::pattern_t            pattern,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  bppc_pkg::cfg_idx_t            cfg_index,
  input  logic [bppc_pkg::LIMIT_BITS-1:0] cfg_data
);

  localparam int CMP_BITS = (SAMPLE_BITS > bppc_pkg::THRESH_BITS) ?
                            SAMPLE_BITS : bppc_pkg::THRESH_BITS;

  logic [bppc_pkg::THRESH_BITS-1:0] press_threshold;
  logic [bppc_pkg::LIMIT_BITS-1:0]  separation_ticks;
  logic [bppc_pkg::LIMIT_BITS-1:0]  short_limit_ticks;
  logic [bppc_pkg::LIMIT_BITS-1:0]  medium_limit_ticks;

  logic                 was_pressed;
  logic                 was_pressed_next;
  logic [TIME_BITS-1:0] tick_count;
  logic [TIME_BITS-1:0] stamp      [4];
  logic [TIME_BITS-1:0] stamp_next [4];
  logic [3:0]           stamp_valid;
  logic [3:0]           stamp_valid_next;

  logic                 pressed;
  logic [TIME_BITS-1:0] hold;
  logic [TIME_BITS-1:0] elapsed;
  logic                 emit;
  bppc_pkg::pattern_t   result;

  bppc_pkg::pattern_t   queue [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 accept;
  logic                 push;
  logic                 pop;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign push      = accept && emit;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign pattern   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold    <= bppc_pkg::THRESHOLD_RESET;
      separation_ticks   <= bppc_pkg::SEPARATION_RESET;
      short_limit_ticks  <= bppc_pkg::SHORT_RESET;
      medium_limit_ticks <= bppc_pkg::MEDIUM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bppc_pkg::REG_PRESS_THRESHOLD: begin
          press_threshold <= cfg_data[bppc_pkg::THRESH_BITS-1:0];
        end
        bppc_pkg::REG_SEPARATION:   separation_ticks   <= cfg_data;
        bppc_pkg::REG_SHORT_LIMIT:  short_limit_ticks  <= cfg_data;
        bppc_pkg::REG_MEDIUM_LIMIT: medium_limit_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    pressed          = CMP_BITS'(sample) < CMP_BITS'(press_threshold);
    was_pressed_next = was_pressed;
    stamp_valid_next = stamp_valid;
    for (int i = 0; i < 4; i++) begin
      stamp_next[i] = stamp[i];
    end

    if (pressed != was_pressed) begin
      was_pressed_next = pressed;
      if (pressed) begin
        if (stamp_valid[bppc_pkg::STAMP_PRESS1]) begin
          stamp_next[bppc_pkg::STAMP_PRESS2]       = tick_count;
          stamp_valid_next[bppc_pkg::STAMP_PRESS2] = 1'b1;
        end else begin
          stamp_next[bppc_pkg::STAMP_PRESS1]       = tick_count;
          stamp_valid_next[bppc_pkg::STAMP_PRESS1] = 1'b1;
        end
      end else begin
        if (stamp_valid[bppc_pkg::STAMP_RELEASE1]) begin
          stamp_next[bppc_pkg::STAMP_RELEASE2]       = tick_count;
          stamp_valid_next[bppc_pkg::STAMP_RELEASE2] = 1'b1;
        end else begin
          stamp_next[bppc_pkg::STAMP_RELEASE1]       = tick_count;
          stamp_valid_next[bppc_pkg::STAMP_RELEASE1] = 1'b1;
        end
      end
    end

    hold    = stamp_next[bppc_pkg::STAMP_RELEASE1] - stamp_next[bppc_pkg::STAMP_PRESS1];
    elapsed = tick_count - stamp_next[bppc_pkg::STAMP_RELEASE1];
    emit    = 1'b0;
    result  = bppc_pkg::PAT_SINGLE_SHORT;

    if (stamp_valid_next[bppc_pkg::STAMP_PRESS1] &&
        stamp_valid_next[bppc_pkg::STAMP_RELEASE1]) begin
      if ((elapsed > TIME_BITS'(separation_ticks)) &&
          !stamp_valid_next[bppc_pkg::STAMP_PRESS2]) begin
        emit = 1'b1;
        if (hold < TIME_BITS'(short_limit_ticks)) begin
          result = bppc_pkg::PAT_SINGLE_SHORT;
        end else if (hold < TIME_BITS'(medium_limit_ticks)) begin
          result = bppc_pkg::PAT_SINGLE_MEDIUM;
        end else begin
          result = bppc_pkg::PAT_SINGLE_LONG;
        end
      end else if (stamp_valid_next[bppc_pkg::STAMP_PRESS2] &&
                   stamp_valid_next[bppc_pkg::STAMP_RELEASE2]) begin
        emit   = 1'b1;
        result = (hold < TIME_BITS'(short_limit_ticks)) ?
                 bppc_pkg::PAT_DOUBLE_SHORT : bppc_pkg::PAT_DOUBLE_LONG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_pressed <= 1'b0;
      tick_count  <= '0;
      stamp_valid <= '0;
    end else if (accept) begin
      was_pressed <= was_pressed_next;
      tick_count  <= tick_count + TIME_BITS'(1);
      stamp_valid <= emit ? 4'b0000 : stamp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        stamp[i] <= stamp_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= result;
    end
  end

  `BPPC_ASSERT_NEXT(a_clear_after_pattern, push, stamp_valid == 4'b0000,
    "Edge stamps not cleared after a pattern was reported.")

  `BPPC_ASSERT_SAME(a_stamp_order, 1'b1,
    (!stamp_valid[bppc_pkg::STAMP_RELEASE1] || stamp_valid[bppc_pkg::STAMP_PRESS1]) &&
    (!stamp_valid[bppc_pkg::STAMP_PRESS2] || stamp_valid[bppc_pkg::STAMP_RELEASE1]) &&
    !stamp_valid[bppc_pkg::STAMP_RELEASE2],
    "Edge stamps were recorded out of order.")

  `BPPC_ASSERT_SAME(a_queue_bound, 1'b1, count != 2'd3,
    "Result queue occupancy out of range.")

  `BPPC_ASSERT_SAME(a_pattern_code, out_valid, pattern <= bppc_pkg::PAT_DOUBLE_LONG,
    "Reported pattern code is not a defined pattern.")

endmodule

### dv/button_press_pattern_classifier_core_checker.sv
// ----------------------------------------------------------------------------
// Button press pattern classifier checker
// Watches the sample, pattern and register write channels of the core. It
// keeps its own copy of the edge stamps and registers, predicts the pattern
// that each accepted sample causes, and compares each pattern that leaves
// the core with the oldest prediction.
// ----------------------------------------------------------------------------
module button_press_pattern_classifier_core_checker
  import bppc_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [SAMPLE_BITS_DEFAULT-1:0] sample,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  pattern_t                       pattern,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  cfg_idx_t                       cfg_index,
  input  logic [LIMIT_BITS-1:0]          cfg_data,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [THRESH_BITS-1:0]       threshold;
  logic [LIMIT_BITS-1:0]        separation;
  logic [LIMIT_BITS-1:0]        short_limit;
  logic [LIMIT_BITS-1:0]        medium_limit;
  logic                         held;
  logic [TIME_BITS_DEFAULT-1:0] tick_now;
  logic [TIME_BITS_DEFAULT-1:0] stamps [4];
  logic                         stamped [4];
  pattern_t                     due_patterns [$];
  pattern_t                     oldest;

  task automatic clear_edges();
    for (int i = 0; i < 4; i++) begin
      stamped[i] = 1'b0;
    end
  endtask

  task automatic classify_tick(input logic [SAMPLE_BITS_DEFAULT-1:0] level);
    logic [TIME_BITS_DEFAULT-1:0] now;
    logic [TIME_BITS_DEFAULT-1:0] hold;
    logic [TIME_BITS_DEFAULT-1:0] elapsed;
    logic                         down;
    int                           slot;
    now = tick_now;
    down = level < threshold;
    tick_now = tick_now + 1'b1;
    if (down != held) begin
      if (down) begin
        slot = stamped[STAMP_PRESS1] ? STAMP_PRESS2 : STAMP_PRESS1;
      end else begin
        slot = stamped[STAMP_RELEASE1] ? STAMP_RELEASE2 : STAMP_RELEASE1;
      end
      stamps[slot] = now;
      stamped[slot] = 1'b1;
      held = down;
    end
    if (stamped[STAMP_PRESS1] && stamped[STAMP_RELEASE1]) begin
      hold = stamps[STAMP_RELEASE1] - stamps[STAMP_PRESS1];
      elapsed = now - stamps[STAMP_RELEASE1];
      if (elapsed > separation && !stamped[STAMP_PRESS2]) begin
        if (hold < short_limit) begin
          due_patterns.push_back(PAT_SINGLE_SHORT);
        end else if (hold < medium_limit) begin
          due_patterns.push_back(PAT_SINGLE_MEDIUM);
        end else begin
          due_patterns.push_back(PAT_SINGLE_LONG);
        end
        clear_edges();
      end else if (stamped[STAMP_PRESS2] && stamped[STAMP_RELEASE2]) begin
        due_patterns.push_back(hold < short_limit ? PAT_DOUBLE_SHORT : PAT_DOUBLE_LONG);
        clear_edges();
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      threshold = THRESHOLD_RESET;
      separation = SEPARATION_RESET;
      short_limit = SHORT_RESET;
      medium_limit = MEDIUM_RESET;
      held = 1'b0;
      tick_now = '0;
      clear_edges();
      due_patterns.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PRESS_THRESHOLD: threshold = cfg_data[THRESH_BITS-1:0];
          REG_SEPARATION:      separation = cfg_data;
          REG_SHORT_LIMIT:     short_limit = cfg_data;
          REG_MEDIUM_LIMIT:    medium_limit = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_patterns.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected pattern, expected none, actual %0d", $time, pattern);
        end else begin
          oldest = due_patterns.pop_front();
          if (pattern !== oldest) begin
            fail_count++;
            $display("%0t: pattern mismatch, expected %0d, actual %0d",
                     $time, oldest, pattern);
          end
        end
      end
      if (in_valid && !in_stall) begin
        classify_tick(sample);
      end
    end
    pending = due_patterns.size();
  end

endmodule

### dv/button_press_pattern_classifier_core_tb.sv
// ----------------------------------------------------------------------------
// Button press pattern classifier testbench
// Drives press and release sequences of random lengths and levels through
// the core under many register settings, with random input gaps and output
// stalls, and lets the checker compare every reported pattern.
// ----------------------------------------------------------------------------
module button_press_pattern_classifier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bppc_pkg::*;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  logic [SAMPLE_BITS_DEFAULT-1:0] sample;
  logic                           out_valid;
  logic                           out_stall;
  pattern_t                       pattern;
  logic                           cfg_valid;
  logic                           cfg_ready;
  cfg_idx_t                       cfg_index;
  logic [LIMIT_BITS-1:0]          cfg_data;
  int                             fail_count;
  int                             pending;

  int   items_sent = 0;
  bit   quiet = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;
  int   idle_run = 0;
  int   threshold_now;
  int   separation_now;
  int   medium_now;

  button_press_pattern_classifier_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pattern   (pattern),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  button_press_pattern_classifier_core_checker pattern_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pattern    (pattern),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The pattern receiver stalls at random outside the quiet phases, and once holds off for a long
  // stretch so that the result queue fills and the core stalls its input.
  always @(negedge clk) begin
    if (!hold_done && items_sent >= 60) begin
      hold_left = 150;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99, 0) < 37);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= 2000) begin
      $display("button_press_pattern_classifier_core test failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  function automatic int clip40(input int v);
    return v > 40 ? 40 : v;
  endfunction

  function automatic logic [LIMIT_BITS-1:0] pick_limit(input int top_small);
    int r;
    r = $urandom_range(99, 0);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return LIMIT_BITS'($urandom_range(top_small, 0));
  endfunction

  function automatic logic [SAMPLE_BITS_DEFAULT-1:0] pressed_level();
    if (threshold_now == 0) return SAMPLE_BITS_DEFAULT'($urandom);
    return SAMPLE_BITS_DEFAULT'($urandom_range(threshold_now - 1, 0));
  endfunction

  function automatic logic [SAMPLE_BITS_DEFAULT-1:0] released_level();
    return SAMPLE_BITS_DEFAULT'($urandom_range(1023, threshold_now));
  endfunction

  task automatic push_sample(input logic [SAMPLE_BITS_DEFAULT-1:0] level);
    forever begin
      @(negedge clk);
      if (quiet || $urandom_range(99, 0) >= 37) break;
      in_valid <= 1'b0;
      sample <= SAMPLE_BITS_DEFAULT'($urandom);
    end
    in_valid <= 1'b1;
    sample <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_press(input int hold, input int gap);
    repeat (hold) push_sample(pressed_level());
    repeat (gap) push_sample(released_level());
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [LIMIT_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [LIMIT_BITS-1:0] thr_data,
                            input logic [LIMIT_BITS-1:0] sep,
                            input logic [LIMIT_BITS-1:0] short_lim,
                            input logic [LIMIT_BITS-1:0] medium_lim);
    write_reg(REG_PRESS_THRESHOLD, thr_data);
    write_reg(REG_SEPARATION, sep);
    write_reg(REG_SHORT_LIMIT, short_lim);
    write_reg(REG_MEDIUM_LIMIT, medium_lim);
    @(negedge clk);
    cfg_valid <= 1'b0;
    threshold_now = int'(thr_data[THRESH_BITS-1:0]);
    separation_now = int'(sep);
    medium_now = int'(medium_lim);
  endtask

  initial begin
    int                     phase;
    int                     kind;
    int                     hold;
    int                     phase_end;
    int                     r;
    logic [THRESH_BITS-1:0] thr;
    rst = 1'b1;
    in_valid = 1'b0;
    sample = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_PRESS_THRESHOLD;
    cfg_data = '0;
    threshold_now = int'(THRESHOLD_RESET);
    separation_now = int'(SEPARATION_RESET);
    medium_now = int'(MEDIUM_RESET);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A quick double press right around the threshold under reset values.
    push_sample(10'd999);
    push_sample(10'd1000);
    push_sample(10'd0);
    push_sample(10'd1023);
    settle();

    // One of each pattern, the last one with a second press that outlasts
    // the separation time.
    set_config(16'd512, 16'd1, 16'd2, 16'd4);
    send_press(1, 3);
    send_press(2, 3);
    send_press(4, 3);
    send_press(1, 1);
    send_press(1, 1);
    send_press(2, 1);
    send_press(3, 1);

    phase = 0;
    while (items_sent < 1700) begin
      settle();
      case (phase)
        0: set_config(16'hFFFF, 16'd0, 16'd0, 16'd0);
        1: set_config(16'hFC00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: set_config(16'h01FF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: begin
          r = $urandom_range(99, 0);
          if (r < 10) thr = '0;
          else if (r < 20) thr = '1;
          else thr = THRESH_BITS'($urandom_range(1023, 1));
          set_config({6'($urandom), thr}, pick_limit(30), pick_limit(20), pick_limit(40));
        end
      endcase
      quiet = (phase == 4 || phase == 5);
      phase_end = items_sent + (threshold_now == 0 ? 30 : int'($urandom_range(160, 80)));
      if (phase_end > 1700) phase_end = 1700;
      while (items_sent < phase_end) begin
        kind = $urandom_range(99, 0);
        hold = $urandom_range(clip40(medium_now) + 2, 1);
        if (kind < 40) begin
          send_press(hold, clip40(separation_now) + $urandom_range(3, 1));
        end else if (kind < 80) begin
          send_press(hold, $urandom_range(clip40(separation_now) + 1, 1));
          send_press($urandom_range(clip40(separation_now) + 3, 1),
                     clip40(separation_now) + $urandom_range(3, 1));
        end else begin
          repeat ($urandom_range(8, 1)) push_sample(SAMPLE_BITS_DEFAULT'($urandom));
        end
      end
      phase++;
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("button_press_pattern_classifier_core test passed");
    end else begin
      $display("button_press_pattern_classifier_core test failed");
    end
    $finish;
  end

endmodule
